[sv/lsb_pkg.sv]
`timescale 1ns / 1ps
// link supervisor package: mode codes, register indexes, reset values and result type
// no dependencies

package lsb_pkg;

  // supervisor modes
  localparam logic [1:0] MODE_CONFIG     = 2'd0;
  localparam logic [1:0] MODE_CONNECTING = 2'd1;
  localparam logic [1:0] MODE_OPERATION  = 2'd2;
  localparam logic [1:0] MODE_EMERGENCY  = 2'd3;

  // last sampled level, with a marker for not yet seen
  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CONNECT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_OP_LOG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_EM_LOG_PERIOD   = 3'd2;
  localparam logic [2:0] REG_BACKOFF_START   = 3'd3;
  localparam logic [2:0] REG_BACKOFF_CAP     = 3'd4;
  localparam logic [2:0] REG_TICK_MS         = 3'd5;

  // register reset values
  localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd300;
  localparam logic [15:0] RST_OP_LOG_PERIOD   = 16'd100;
  localparam logic [15:0] RST_EM_LOG_PERIOD   = 16'd20;
  localparam logic [15:0] RST_BACKOFF_START   = 16'd1000;
  localparam logic [15:0] RST_BACKOFF_CAP     = 16'd60000;
  localparam logic [9:0]  RST_TICK_MS         = 10'd50;

  // clear mask bits
  localparam logic [2:0] CLR_ALL          = 3'b111;
  localparam logic [2:0] CLR_CONNECTED    = 3'b010;
  localparam logic [2:0] CLR_DISCONNECTED = 3'b100;

  // x / 1000 for x < 2**16 as (x * 67109) >> 26
  localparam logic [16:0] MS_TO_S_RECIP = 17'd67109;
  localparam int unsigned MS_TO_S_SHIFT = 26;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  typedef struct packed {
    logic [1:0]  mode;
    logic        drive_level;
    logic        record_request;
    logic        record_kind;
    logic [31:0] record_seq;
    logic        record_level;
    logic        reconnect_request;
    logic        start_station;
    logic        start_access_point;
    logic        stop_portal;
    logic [2:0]  clear_events;
    logic [6:0]  retry_seconds;
  } lsb_result_t;

endpackage

[sv/link_supervisor_with_backoff_top.sv]
`timescale 1ns / 1ps
// link supervisor top: one-pass mode/counter update with registered result
// latency: result is presented the cycle after the input transfer
// throughput: one item per cycle; input ready drops only while a result waits unaccepted
// reset: config mode, counters and drive cleared, registers at their default values
// depends on lsb_pkg

module link_supervisor_with_backoff_top
  import lsb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // has_credentials, ev_credentials, ev_connected, ev_disconnected, signal_level, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                  s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // mode[1:0], drive_level, record_request, record_seq[31:0], record_level,
  // reconnect_request, start_station, start_access_point, stop_portal,
  // clear_events[2:0], retry_seconds[6:0], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // record_kind
  output logic                  m_axis_tuser
);

  // configuration registers
  logic [15:0] connect_timeout_q, op_period_q, em_period_q, backoff_start_q, backoff_cap_q;
  logic [9:0]  tick_ms_q;

  // supervisor state
  logic [1:0]  mode_q, mode_d;
  logic [31:0] tick_count_q, tick_count_d;
  logic [15:0] op_phase_q, op_phase_d;
  logic [31:0] op_seq_q, op_seq_d;
  logic [15:0] em_phase_q, em_phase_d;
  logic [15:0] connect_ticks_q, connect_ticks_d;
  logic [15:0] backoff_q, backoff_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [1:0]  last_level_q, last_level_d;
  logic        drive_q, drive_d;

  // result register
  lsb_result_t res_d, res_q;
  logic        out_valid_q;

  logic in_fire;

  // input fields
  logic has_cred, ev_cred, ev_conn, ev_disc, level;

  // datapath helpers
  logic [16:0] elapsed_sum;
  logic [15:0] elapsed_sat;
  logic [16:0] backoff_dbl;
  logic [15:0] backoff_new;
  logic [33:0] retry_prod;
  logic [16:0] op_phase_inc, em_phase_inc;
  logic [15:0] op_period, em_period;

  assign has_cred = s_axis_tdata[0];
  assign ev_cred  = s_axis_tdata[1];
  assign ev_conn  = s_axis_tdata[2];
  assign ev_disc  = s_axis_tdata[3];
  assign level    = s_axis_tdata[4];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // backoff arithmetic for an emergency tick
  assign elapsed_sum = {1'b0, elapsed_q} + {7'd0, tick_ms_q};
  assign elapsed_sat = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
  assign backoff_dbl = {backoff_q, 1'b0};
  assign backoff_new = (backoff_dbl < {1'b0, backoff_cap_q}) ? backoff_dbl[15:0]
                                                             : backoff_cap_q;
  assign retry_prod  = {1'b0, backoff_new} * MS_TO_S_RECIP;

  // log period phases, zero period acts as one
  assign op_period    = (op_period_q == 16'd0) ? 16'd1 : op_period_q;
  assign em_period    = (em_period_q == 16'd0) ? 16'd1 : em_period_q;
  assign op_phase_inc = {1'b0, op_phase_q} + 17'd1;
  assign em_phase_inc = {1'b0, em_phase_q} + 17'd1;

  always_comb begin
    mode_d          = mode_q;
    tick_count_d    = tick_count_q;
    op_phase_d      = op_phase_q;
    op_seq_d        = op_seq_q;
    em_phase_d      = em_phase_q;
    connect_ticks_d = connect_ticks_q;
    backoff_d       = backoff_q;
    elapsed_d       = elapsed_q;
    last_level_d    = last_level_q;
    drive_d         = drive_q;
    res_d           = '0;

    if (s_axis_tuser) begin
      // start decision, event flags ignored
      if (has_cred) begin
        res_d.start_station = 1'b1;
        mode_d              = MODE_CONNECTING;
        connect_ticks_d     = 16'd0;
      end else begin
        res_d.start_access_point = 1'b1;
        mode_d                   = MODE_CONFIG;
      end
    end else begin
      case (mode_q)
        MODE_CONFIG: begin
          if (ev_cred) begin
            res_d.clear_events  = CLR_ALL;
            res_d.stop_portal   = 1'b1;
            res_d.start_station = 1'b1;
            connect_ticks_d     = 16'd0;
            mode_d              = MODE_CONNECTING;
          end
        end
        MODE_CONNECTING: begin
          if (ev_conn) begin
            mode_d = MODE_OPERATION;
          end else if (ev_disc || connect_ticks_q >= connect_timeout_q) begin
            res_d.start_access_point = 1'b1;
            mode_d                   = MODE_CONFIG;
          end else if (connect_ticks_q != 16'hFFFF) begin
            connect_ticks_d = connect_ticks_q + 16'd1;
          end
        end
        MODE_OPERATION: begin
          if (ev_disc) begin
            res_d.clear_events = CLR_DISCONNECTED;
            backoff_d          = backoff_start_q;
            elapsed_d          = 16'd0;
            mode_d             = MODE_EMERGENCY;
          end else begin
            if ({1'b0, level} != last_level_q) begin
              last_level_d = {1'b0, level};
              drive_d      = level;
            end
            if (op_phase_q == 16'd0 && tick_count_q != 32'd0) begin
              res_d.record_request = 1'b1;
              res_d.record_seq     = op_seq_q;
              res_d.record_level   = level;
            end
          end
        end
        default: begin
          drive_d = 1'b0;
          if (em_phase_q == 16'd0) begin
            res_d.record_request = 1'b1;
            res_d.record_kind    = 1'b1;
            res_d.record_seq     = tick_count_q;
            res_d.record_level   = level;
          end
          elapsed_d = elapsed_sat;
          if (elapsed_sat >= backoff_q) begin
            elapsed_d               = 16'd0;
            backoff_d               = backoff_new;
            res_d.reconnect_request = 1'b1;
            res_d.retry_seconds     = retry_prod[MS_TO_S_SHIFT +: 7];
          end
          // connected event wins over the backoff update
          if (ev_conn) begin
            res_d.clear_events = res_d.clear_events | CLR_CONNECTED;
            backoff_d          = backoff_start_q;
            elapsed_d          = 16'd0;
            mode_d             = MODE_OPERATION;
            last_level_d       = LEVEL_UNKNOWN;
          end
        end
      endcase

      tick_count_d = tick_count_q + 32'd1;
      if (op_phase_inc >= {1'b0, op_period}) begin
        op_phase_d = 16'd0;
        op_seq_d   = op_seq_q + 32'd1;
      end else begin
        op_phase_d = op_phase_inc[15:0];
      end
      if (em_phase_inc >= {1'b0, em_period}) begin
        em_phase_d = 16'd0;
      end else begin
        em_phase_d = em_phase_inc[15:0];
      end
    end

    res_d.mode        = mode_d;
    res_d.drive_level = drive_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_timeout_q <= RST_CONNECT_TIMEOUT;
      op_period_q       <= RST_OP_LOG_PERIOD;
      em_period_q       <= RST_EM_LOG_PERIOD;
      backoff_start_q   <= RST_BACKOFF_START;
      backoff_cap_q     <= RST_BACKOFF_CAP;
      tick_ms_q         <= RST_TICK_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONNECT_TIMEOUT: connect_timeout_q <= cfg_wdata_i;
        REG_OP_LOG_PERIOD:   op_period_q       <= cfg_wdata_i;
        REG_EM_LOG_PERIOD:   em_period_q       <= cfg_wdata_i;
        REG_BACKOFF_START:   backoff_start_q   <= cfg_wdata_i;
        REG_BACKOFF_CAP:     backoff_cap_q     <= cfg_wdata_i;
        REG_TICK_MS:         tick_ms_q         <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_CONFIG;
      tick_count_q    <= 32'd0;
      op_phase_q      <= 16'd0;
      op_seq_q        <= 32'd0;
      em_phase_q      <= 16'd0;
      connect_ticks_q <= 16'd0;
      backoff_q       <= RST_BACKOFF_START;
      elapsed_q       <= 16'd0;
      last_level_q    <= LEVEL_UNKNOWN;
      drive_q         <= 1'b0;
    end else if (in_fire) begin
      mode_q          <= mode_d;
      tick_count_q    <= tick_count_d;
      op_phase_q      <= op_phase_d;
      op_seq_q        <= op_seq_d;
      em_phase_q      <= em_phase_d;
      connect_ticks_q <= connect_ticks_d;
      backoff_q       <= backoff_d;
      elapsed_q       <= elapsed_d;
      last_level_q    <= last_level_d;
      drive_q         <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.record_kind;
  assign m_axis_tdata  = {5'd0,
                          res_q.retry_seconds,
                          res_q.clear_events,
                          res_q.stop_portal,
                          res_q.start_access_point,
                          res_q.start_station,
                          res_q.reconnect_request,
                          res_q.record_level,
                          res_q.record_seq,
                          res_q.record_request,
                          res_q.drive_level,
                          res_q.mode};

  // a reconnect pulse only comes from an emergency tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.reconnect_request |->
      (res_q.mode == MODE_EMERGENCY || res_q.mode == MODE_OPERATION))
    else $error("reconnect request outside emergency handling");

  // an emergency record always goes out with the drive held low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.record_request && res_q.record_kind |-> !res_q.drive_level)
    else $error("emergency record with drive high");

  // a station start always leaves the supervisor connecting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.start_station |-> res_q.mode == MODE_CONNECTING)
    else $error("station start without connecting mode");

  // the mode only moves on an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(mode_q))
    else $error("mode changed without a transfer");

endmodule

[test/tb_link_supervisor_with_backoff_top.sv]
`timescale 1ns / 1ps
// testbench for link_supervisor_with_backoff_top: directed and random tick/start streams
// checked against an in-bench model of the supervisor, under several idle patterns
// depends on lsb_pkg and the top module only

module tb_link_supervisor_with_backoff_top;
  import lsb_pkg::*;

  localparam logic ACT_TICK      = 1'b0;
  localparam logic ACT_START     = 1'b1;
  localparam logic REC_OPERATION = 1'b0;
  localparam logic REC_EMERGENCY = 1'b1;

  typedef struct packed {
    logic action;
    logic has_cred;
    logic ev_cred;
    logic ev_conn;
    logic ev_disc;
    logic level;
  } sup_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = '0;
  logic [15:0]           cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  link_supervisor_with_backoff_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // register copies
  logic [15:0] timeout_lim = RST_CONNECT_TIMEOUT;
  logic [15:0] op_period   = RST_OP_LOG_PERIOD;
  logic [15:0] em_period   = RST_EM_LOG_PERIOD;
  logic [15:0] bo_start    = RST_BACKOFF_START;
  logic [15:0] bo_cap      = RST_BACKOFF_CAP;
  logic [9:0]  tick_len    = RST_TICK_MS;

  // supervisor state copies
  logic [1:0]  cur_mode        = MODE_CONFIG;
  logic [31:0] tick_total      = '0;
  logic [15:0] op_phase        = '0;
  logic [31:0] op_seq          = '0;
  logic [15:0] em_phase        = '0;
  logic [15:0] conn_ticks      = '0;
  logic [15:0] backoff_cur     = RST_BACKOFF_START;
  logic [15:0] backoff_elapsed = '0;
  logic [1:0]  last_level      = LEVEL_UNKNOWN;
  logic        drive_q         = 1'b0;

  sup_item_t   pending_items[$];
  lsb_result_t expected_results[$];

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned record_total = 0;
  int unsigned reconnect_total = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_taken = 1'b0;
  logic        gen_level = 1'b0;

  function automatic lsb_result_t advance_supervisor(sup_item_t it);
    lsb_result_t r;
    logic [31:0] sum;
    logic [31:0] nxt_bo;
    logic [31:0] phase_n;
    r = '0;
    if (it.action == ACT_START) begin
      // start re-decides from scratch, event flags play no part
      if (it.has_cred) begin
        r.start_station = 1'b1;
        cur_mode = MODE_CONNECTING;
        conn_ticks = '0;
      end else begin
        r.start_access_point = 1'b1;
        cur_mode = MODE_CONFIG;
      end
    end else begin
      case (cur_mode)
        MODE_CONFIG: begin
          if (it.ev_cred) begin
            r.clear_events = CLR_ALL;
            r.stop_portal = 1'b1;
            r.start_station = 1'b1;
            conn_ticks = '0;
            cur_mode = MODE_CONNECTING;
          end
        end
        MODE_CONNECTING: begin
          if (it.ev_conn) begin
            cur_mode = MODE_OPERATION;
          end else if (it.ev_disc || conn_ticks >= timeout_lim) begin
            r.start_access_point = 1'b1;
            cur_mode = MODE_CONFIG;
          end else if (conn_ticks != 16'hFFFF) begin
            conn_ticks = conn_ticks + 16'd1;
          end
        end
        MODE_OPERATION: begin
          if (it.ev_disc) begin
            r.clear_events = CLR_DISCONNECTED;
            backoff_cur = bo_start;
            backoff_elapsed = '0;
            cur_mode = MODE_EMERGENCY;
          end else begin
            if ({1'b0, it.level} != last_level) begin
              last_level = {1'b0, it.level};
              drive_q = it.level;
            end
            if (op_phase == '0 && tick_total != '0) begin
              r.record_request = 1'b1;
              r.record_kind = REC_OPERATION;
              r.record_seq = op_seq;
              r.record_level = it.level;
            end
          end
        end
        default: begin
          drive_q = 1'b0;
          if (em_phase == '0) begin
            r.record_request = 1'b1;
            r.record_kind = REC_EMERGENCY;
            r.record_seq = tick_total;
            r.record_level = it.level;
          end
          // elapsed time saturates at 16 bits
          sum = 32'(backoff_elapsed) + 32'(tick_len);
          if (sum > 32'hFFFF) sum = 32'hFFFF;
          if (sum >= 32'(backoff_cur)) begin
            nxt_bo = 32'(backoff_cur) * 32'd2;
            backoff_cur = (nxt_bo < 32'(bo_cap)) ? nxt_bo[15:0] : bo_cap;
            sum = '0;
            r.reconnect_request = 1'b1;
            r.retry_seconds = 7'(backoff_cur / 16'd1000);
          end
          backoff_elapsed = sum[15:0];
          if (it.ev_conn) begin
            r.clear_events = r.clear_events | CLR_CONNECTED;
            backoff_cur = bo_start;
            backoff_elapsed = '0;
            cur_mode = MODE_OPERATION;
            last_level = LEVEL_UNKNOWN;
          end
        end
      endcase
      tick_total = tick_total + 32'd1;
      // a zero period behaves as one
      phase_n = 32'(op_phase) + 32'd1;
      if (phase_n >= ((op_period == '0) ? 32'd1 : 32'(op_period))) begin
        op_phase = '0;
        op_seq = op_seq + 32'd1;
      end else begin
        op_phase = phase_n[15:0];
      end
      phase_n = 32'(em_phase) + 32'd1;
      if (phase_n >= ((em_period == '0) ? 32'd1 : 32'(em_period))) em_phase = '0;
      else em_phase = phase_n[15:0];
    end
    r.mode = cur_mode;
    r.drive_level = drive_q;
    return r;
  endfunction

  function automatic sup_item_t make_item(logic act, logic cred, logic ec, logic en,
                                          logic ed, logic lvl);
    sup_item_t it;
    it.action = act;
    it.has_cred = cred;
    it.ev_cred = ec;
    it.ev_conn = en;
    it.ev_disc = ed;
    it.level = lvl;
    return it;
  endfunction

  task automatic queue_item(sup_item_t it);
    pending_items.push_back(it);
    queued_total++;
  endtask

  // bursts of ticks with per-burst event rates, plus stray starts and noise
  task automatic queue_random(int unsigned n);
    int unsigned made, burst, j, roll, cred_pct, conn_pct, disc_pct;
    sup_item_t it;
    made = 0;
    while (made < n) begin
      burst = $urandom_range(5, 60);
      cred_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 30);
      conn_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 30);
      disc_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 30);
      for (j = 0; j < burst && made < n; j++) begin
        roll = $urandom_range(99);
        if ($urandom_range(3) == 0) gen_level = ~gen_level;
        if (roll < 3) begin
          it = make_item(ACT_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)), gen_level);
        end else if (roll < 8) begin
          it = sup_item_t'($urandom_range(63));
        end else begin
          it = make_item(ACT_TICK, 1'($urandom_range(1)), $urandom_range(99) < cred_pct,
                         $urandom_range(99) < conn_pct, $urandom_range(99) < disc_pct,
                         gen_level);
        end
        queue_item(it);
        made++;
      end
    end
  endtask

  task automatic set_register(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_CONNECT_TIMEOUT: timeout_lim = val;
      REG_OP_LOG_PERIOD:   op_period = val;
      REG_EM_LOG_PERIOD:   em_period = val;
      REG_BACKOFF_START:   bo_start = val;
      REG_BACKOFF_CAP:     bo_cap = val;
      REG_TICK_MS:         tick_len = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] tmo, logic [15:0] opp, logic [15:0] emp,
                                logic [15:0] bst, logic [15:0] bcap, logic [15:0] tms);
    set_register(REG_CONNECT_TIMEOUT, tmo);
    set_register(REG_OP_LOG_PERIOD, opp);
    set_register(REG_EM_LOG_PERIOD, emp);
    set_register(REG_BACKOFF_START, bst);
    set_register(REG_BACKOFF_CAP, bcap);
    set_register(REG_TICK_MS, tms);
  endtask

  // holds the test sequence until every queued item has come back as a result
  task automatic wait_drained();
    while (accepted_total != queued_total || expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // input side: one item held until its transfer completes
  always @(negedge clk_i) begin
    sup_item_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, nxt.level, nxt.ev_disc, nxt.ev_conn, nxt.ev_cred,
                         nxt.has_cred};
        s_axis_tuser <= nxt.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    lsb_result_t want, got;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.mode = m_axis_tdata[1:0];
        got.drive_level = m_axis_tdata[2];
        got.record_request = m_axis_tdata[3];
        got.record_kind = m_axis_tuser;
        got.record_seq = m_axis_tdata[35:4];
        got.record_level = m_axis_tdata[36];
        got.reconnect_request = m_axis_tdata[37];
        got.start_station = m_axis_tdata[38];
        got.start_access_point = m_axis_tdata[39];
        got.stop_portal = m_axis_tdata[40];
        got.clear_events = m_axis_tdata[43:41];
        got.retry_seconds = m_axis_tdata[50:44];
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result transfer, expected none, actual %0h/%0b", $time,
                   m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_results.pop_front();
          checked_total++;
          check_field("mode", want.mode, got.mode);
          check_field("drive_level", want.drive_level, got.drive_level);
          check_field("record_request", want.record_request, got.record_request);
          check_field("record_kind", want.record_kind, got.record_kind);
          check_field("record_seq", want.record_seq, got.record_seq);
          check_field("record_level", want.record_level, got.record_level);
          check_field("reconnect_request", want.reconnect_request, got.reconnect_request);
          check_field("start_station", want.start_station, got.start_station);
          check_field("start_access_point", want.start_access_point, got.start_access_point);
          check_field("stop_portal", want.stop_portal, got.stop_portal);
          check_field("clear_events", want.clear_events, got.clear_events);
          check_field("retry_seconds", want.retry_seconds, got.retry_seconds);
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        want = advance_supervisor(make_item(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
                                            s_axis_tdata[2], s_axis_tdata[3],
                                            s_axis_tdata[4]));
        expected_results.push_back(want);
        accepted_total++;
        if (want.record_request) record_total++;
        if (want.reconnect_request) reconnect_total++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("run limit reached with %0d of %0d items accepted", accepted_total, queued_total);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk through every mode at the reset settings
    queue_item(make_item(ACT_START, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 1, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 1, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 1, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 1, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 1, 0, 0));
    queue_item(make_item(ACT_START, 1, 1, 1, 1, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 1, 0));
    wait_drained();

    // zero log periods, zero backoff and a short connect timeout
    apply_settings(16'd2, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1000);
    queue_item(make_item(ACT_START, 1, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_START, 1, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 1, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 1, 0, 0, 0, 1));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 1, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 1));
    queue_item(make_item(ACT_START, 0, 1, 1, 1, 0));
    queue_item(make_item(ACT_TICK, 0, 1, 1, 1, 1));
    wait_drained();

    apply_settings(16'd8, 16'd3, 16'd5, 16'd1000, 16'd9000, 16'd400);
    queue_random(130);
    wait_drained();

    send_idle_pct = 72;
    apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    queue_random(130);
    wait_drained();

    // top settings: long emergency stay drives elapsed time into saturation
    send_idle_pct = 0;
    recv_stall_pct = 72;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000);
    queue_item(make_item(ACT_START, 1, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 1, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 1, 0));
    repeat (70) queue_item(make_item(ACT_TICK, 1'($urandom_range(1)), 0, 0, 0,
                                     1'($urandom_range(1))));
    queue_random(57);
    wait_drained();

    send_idle_pct = 17;
    recv_stall_pct = 17;
    apply_settings(16'($urandom_range(1, 20)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(1, 12)), 16'($urandom_range(1, 8000)),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 1000)));
    queue_random(130);

    while (accepted_total != queued_total) @(negedge clk_i);
    for (n = 0; n < 1000 && expected_results.size() != 0; n++) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_results.size());
    end

    $display("covered %0d input transfers across six register settings and four idle patterns",
             accepted_total);
    $display("%0d results compared, %0d log records and %0d reconnect pulses among them",
             checked_total, record_total, reconnect_total);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
